// File: rtl/fsa_pkg.sv
package fsa_pkg;

    // field widths
    localparam int TIME_BITS      = 48;
    localparam int COUNTER_BITS   = 32;
    localparam int COUNT_BITS     = 32;
    localparam int RATE_BITS      = 32;
    localparam int RUN_BITS       = 8;
    localparam int PUSH_BITS      = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // register reset values
    localparam logic [RATE_BITS-1:0] SLOT_RATE_RESET      = 32'd128849;
    localparam logic                 COUNTER_ENABLE_RESET = 1'b1;
    localparam logic [RUN_BITS-1:0]  STUCK_RUN_RESET      = 8'd30;
    localparam logic [PUSH_BITS-1:0] MAX_PUSH_RESET       = 4'd2;

    // action codes
    localparam logic ACTION_SUBMIT = 1'b0;
    localparam logic ACTION_BEGIN  = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_APPEND = 2'd0,
        VERDICT_REPEAT = 2'd1,
        VERDICT_CROWD  = 2'd2,
        VERDICT_BEGIN  = 2'd3
    } fsa_verdict_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SLOT_RATE       = 2'd0,
        CFG_COUNTER_ENABLE  = 2'd1,
        CFG_STUCK_RUN_LIMIT = 2'd2,
        CFG_MAX_PUSH        = 2'd3
    } fsa_cfg_index_t;

    typedef struct packed {
        logic                    action;
        logic [TIME_BITS-1:0]    timestamp;
        logic                    counter_present;
        logic [COUNTER_BITS-1:0] counter_value;
    } fsa_in_t;

    typedef struct packed {
        fsa_verdict_t          verdict;
        logic [TIME_BITS-1:0]  slot_index;
        logic                  stuck_flag;
        logic [COUNT_BITS-1:0] submitted_total;
        logic [COUNT_BITS-1:0] dropped_total;
        logic [COUNT_BITS-1:0] rendered_total;
    } fsa_out_t;

    typedef struct packed {
        logic [RATE_BITS-1:0] slot_rate;
        logic                 counter_enable;
        logic [RUN_BITS-1:0]  stuck_run_limit;
        logic [PUSH_BITS-1:0] max_push;
    } fsa_cfg_t;

    // per-transaction sideband carried down the pipeline
    typedef struct packed {
        fsa_verdict_t          verdict;
        logic                  stuck;
        logic [COUNT_BITS-1:0] submitted;
        logic [COUNT_BITS-1:0] rendered;
    } fsa_meta_t;

endpackage

// File: rtl/fsa_front.sv
module fsa_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           advance,
    input  fsa_pkg::fsa_in_t               in_data,
    input  fsa_pkg::fsa_cfg_t              cfg,
    output logic                           s1_valid,
    output fsa_pkg::fsa_meta_t             s1_meta,
    output logic [fsa_pkg::TIME_BITS-1:0]  s1_elapsed
);
    import fsa_pkg::*;

    logic                    started_reg, started_next;
    logic [TIME_BITS-1:0]    start_time_reg, start_time_next;
    logic                    have_prev_reg, have_prev_next;
    logic [COUNTER_BITS-1:0] prev_counter_reg, prev_counter_next;
    logic                    moved_reg, moved_next;
    logic [RUN_BITS-1:0]     run_reg, run_next;
    logic                    stuck_reg, stuck_next;
    logic [COUNT_BITS-1:0]   submitted_reg, submitted_next;
    logic [COUNT_BITS-1:0]   rendered_reg, rendered_next;

    logic                    s1_valid_reg;
    fsa_meta_t               s1_meta_reg, s1_meta_next;
    logic [TIME_BITS-1:0]    s1_elapsed_reg, s1_elapsed_next;

    logic                    present;
    logic                    drop;
    logic [TIME_BITS-1:0]    start_eff;

    // duplicate / stuck tracking and session start
    always_comb
    begin
        started_next      = started_reg;
        start_time_next   = start_time_reg;
        have_prev_next    = have_prev_reg;
        prev_counter_next = prev_counter_reg;
        moved_next        = moved_reg;
        run_next          = run_reg;
        stuck_next        = stuck_reg;
        submitted_next    = submitted_reg;
        rendered_next     = rendered_reg;
        s1_meta_next      = '0;
        s1_elapsed_next   = '0;
        drop              = 1'b0;
        present           = in_data.counter_present & cfg.counter_enable;
        start_eff         = started_reg ? start_time_reg : in_data.timestamp;

        if (in_data.action == ACTION_BEGIN)
        begin
            started_next      = 1'b0;
            start_time_next   = '0;
            have_prev_next    = 1'b0;
            prev_counter_next = '0;
            moved_next        = 1'b0;
            run_next          = '0;
            stuck_next        = 1'b0;
            submitted_next    = '0;
            rendered_next     = '0;
            s1_meta_next.verdict = VERDICT_BEGIN;
        end
        else
        begin
            submitted_next = submitted_reg + 1'b1;
            s1_meta_next.verdict = VERDICT_APPEND;

            // counter compare against the previous kept frame
            if (present && have_prev_reg)
            begin
                if (in_data.counter_value == prev_counter_reg)
                begin
                    if (run_reg != '1)
                    begin
                        run_next = run_reg + 1'b1;
                    end
                    if ((run_next > cfg.stuck_run_limit) && !moved_reg)
                    begin
                        stuck_next = 1'b1;
                    end
                    if (moved_reg)
                    begin
                        drop = 1'b1;
                    end
                end
                else
                begin
                    moved_next    = 1'b1;
                    run_next      = '0;
                    stuck_next    = 1'b0;
                    rendered_next = rendered_reg + 1'b1;
                end
            end

            if (present && !drop)
            begin
                prev_counter_next = in_data.counter_value;
                have_prev_next    = 1'b1;
            end

            // elapsed time since session start, clamped at zero
            if (drop)
            begin
                s1_meta_next.verdict = VERDICT_REPEAT;
            end
            else
            begin
                started_next    = 1'b1;
                start_time_next = start_eff;
                if (in_data.timestamp >= start_eff)
                begin
                    s1_elapsed_next = in_data.timestamp - start_eff;
                end
            end
        end

        s1_meta_next.stuck     = stuck_next;
        s1_meta_next.submitted = submitted_next;
        s1_meta_next.rendered  = rendered_next;
    end

    // session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg      <= 1'b0;
            start_time_reg   <= '0;
            have_prev_reg    <= 1'b0;
            prev_counter_reg <= '0;
            moved_reg        <= 1'b0;
            run_reg          <= '0;
            stuck_reg        <= 1'b0;
            submitted_reg    <= '0;
            rendered_reg     <= '0;
        end
        else if (accept)
        begin
            started_reg      <= started_next;
            start_time_reg   <= start_time_next;
            have_prev_reg    <= have_prev_next;
            prev_counter_reg <= prev_counter_next;
            moved_reg        <= moved_next;
            run_reg          <= run_next;
            stuck_reg        <= stuck_next;
            submitted_reg    <= submitted_next;
            rendered_reg     <= rendered_next;
        end
    end

    // stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_meta_reg    <= s1_meta_next;
            s1_elapsed_reg <= s1_elapsed_next;
        end
    end

    assign s1_valid   = s1_valid_reg;
    assign s1_meta    = s1_meta_reg;
    assign s1_elapsed = s1_elapsed_reg;

endmodule

// File: rtl/fsa_scale.sv
module fsa_scale (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           s1_valid,
    input  fsa_pkg::fsa_meta_t             s1_meta,
    input  logic [fsa_pkg::TIME_BITS-1:0]  s1_elapsed,
    input  logic [fsa_pkg::RATE_BITS-1:0]  slot_rate,
    output logic                           s3_valid,
    output fsa_pkg::fsa_meta_t             s3_meta,
    output logic [fsa_pkg::TIME_BITS-1:0]  s3_slot
);
    import fsa_pkg::*;

    localparam int EXT_BITS  = 65;
    localparam int PROD_BITS = 64;
    localparam logic [EXT_BITS-1:0] ROUND_HALF = 65'h0_8000_0000;

    logic [PROD_BITS-1:0] elapsed_ext;
    logic [31:0]          lo_op;
    logic [31:0]          hi_op;
    logic [PROD_BITS-1:0] lo_prod_next;
    logic [PROD_BITS-1:0] hi_prod_full;

    logic                 s2_valid_reg;
    fsa_meta_t            s2_meta_reg;
    logic [PROD_BITS-1:0] lo_prod_reg;
    logic [TIME_BITS-1:0] hi_prod_reg;

    logic [EXT_BITS-1:0]  round_sum;
    logic [32:0]          round_term;
    logic [TIME_BITS-1:0] slot_next;

    logic                 s3_valid_reg;
    fsa_meta_t            s3_meta_reg;
    logic [TIME_BITS-1:0] s3_slot_reg;

    // split the elapsed time into two 32-bit halves
    assign elapsed_ext  = {{(PROD_BITS-TIME_BITS){1'b0}}, s1_elapsed};
    assign lo_op        = elapsed_ext[31:0];
    assign hi_op        = elapsed_ext[63:32];
    assign lo_prod_next = PROD_BITS'(lo_op) * PROD_BITS'(slot_rate);
    assign hi_prod_full = PROD_BITS'(hi_op) * PROD_BITS'(slot_rate);

    // stage 2: partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_meta_reg <= s1_meta;
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_full[TIME_BITS-1:0];
        end
    end

    // round half up on the low product and merge
    assign round_sum  = {1'b0, lo_prod_reg} + ROUND_HALF;
    assign round_term = round_sum[64:32];
    assign slot_next  = hi_prod_reg + TIME_BITS'(round_term);

    // stage 3: unresolved slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_meta_reg <= s2_meta_reg;
            s3_slot_reg <= slot_next;
        end
    end

    assign s3_valid = s3_valid_reg;
    assign s3_meta  = s3_meta_reg;
    assign s3_slot  = s3_slot_reg;

endmodule

// File: rtl/fsa_place.sv
module fsa_place (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           s3_valid,
    input  fsa_pkg::fsa_meta_t             s3_meta,
    input  logic [fsa_pkg::TIME_BITS-1:0]  s3_slot,
    input  logic [fsa_pkg::PUSH_BITS-1:0]  max_push,
    output logic                           out_valid,
    output fsa_pkg::fsa_out_t              out_data
);
    import fsa_pkg::*;

    logic                  slot_valid_reg, slot_valid_next;
    logic [TIME_BITS-1:0]  last_slot_reg, last_slot_next;
    logic [COUNT_BITS-1:0] dropped_reg, dropped_next;
    logic                  out_valid_reg;
    fsa_out_t              out_data_reg, out_data_next;

    logic [TIME_BITS:0]    pushed;
    logic [TIME_BITS:0]    push_limit;
    logic [TIME_BITS-1:0]  place;
    logic                  crowd;

    assign pushed     = {1'b0, last_slot_reg} + 1'b1;
    assign push_limit = {1'b0, s3_slot} + (TIME_BITS+1)'(max_push);

    // collision resolution against the last assigned slot
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        last_slot_next  = last_slot_reg;
        dropped_next    = dropped_reg;
        place           = s3_slot;
        crowd           = 1'b0;
        out_data_next   = '0;
        out_data_next.verdict = s3_meta.verdict;

        case (s3_meta.verdict)
            VERDICT_BEGIN:
            begin
                slot_valid_next = 1'b0;
                last_slot_next  = '0;
                dropped_next    = '0;
            end
            VERDICT_REPEAT:
            begin
                dropped_next = dropped_reg + 1'b1;
            end
            VERDICT_APPEND:
            begin
                if (slot_valid_reg && (s3_slot <= last_slot_reg))
                begin
                    if (pushed > push_limit)
                    begin
                        crowd = 1'b1;
                    end
                    else
                    begin
                        place = pushed[TIME_BITS-1:0];
                    end
                end
                if (crowd)
                begin
                    dropped_next          = dropped_reg + 1'b1;
                    out_data_next.verdict = VERDICT_CROWD;
                end
                else
                begin
                    slot_valid_next          = 1'b1;
                    last_slot_next           = place;
                    out_data_next.slot_index = place;
                end
            end
            default:
            begin
                dropped_next = dropped_reg;
            end
        endcase

        out_data_next.stuck_flag      = s3_meta.stuck;
        out_data_next.submitted_total = s3_meta.submitted;
        out_data_next.dropped_total   = dropped_next;
        out_data_next.rendered_total  = s3_meta.rendered;
    end

    // slot history and drop count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            last_slot_reg  <= '0;
            dropped_reg    <= '0;
        end
        else if (advance && s3_valid)
        begin
            slot_valid_reg <= slot_valid_next;
            last_slot_reg  <= last_slot_next;
            dropped_reg    <= dropped_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/frame_slot_assigner_core.sv
// an accepted input transaction is registered at stage 1, stage 2, stage 3 and the result register before out_data
// throughput: one transaction per cycle; the whole pipeline holds while a result is stalled
// stages: session logic, split 32x32 partial products, rounding merge, collision and result
// reset: rst_n clears session state, pipeline valids and loads the register defaults
// a begin action clears the session state in order with the transactions around it
module frame_slot_assigner_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fsa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fsa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  fsa_pkg::fsa_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output fsa_pkg::fsa_out_t                   out_data
);
    import fsa_pkg::*;

    fsa_cfg_t             cfg_reg;
    logic                 advance;
    logic                 accept;

    logic                 s1_valid;
    fsa_meta_t            s1_meta;
    logic [TIME_BITS-1:0] s1_elapsed;
    logic                 s3_valid;
    fsa_meta_t            s3_meta;
    logic [TIME_BITS-1:0] s3_slot;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_rate       <= SLOT_RATE_RESET;
            cfg_reg.counter_enable  <= COUNTER_ENABLE_RESET;
            cfg_reg.stuck_run_limit <= STUCK_RUN_RESET;
            cfg_reg.max_push        <= MAX_PUSH_RESET;
        end
        else if (cfg_write)
        begin
            case (fsa_cfg_index_t'(cfg_index))
                CFG_SLOT_RATE:       cfg_reg.slot_rate       <= cfg_data[RATE_BITS-1:0];
                CFG_COUNTER_ENABLE:  cfg_reg.counter_enable  <= cfg_data[0];
                CFG_STUCK_RUN_LIMIT: cfg_reg.stuck_run_limit <= cfg_data[RUN_BITS-1:0];
                CFG_MAX_PUSH:        cfg_reg.max_push        <= cfg_data[PUSH_BITS-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // pipeline moves unless a finished result is held
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    fsa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .advance    (advance),
        .in_data    (in_data),
        .cfg        (cfg_reg),
        .s1_valid   (s1_valid),
        .s1_meta    (s1_meta),
        .s1_elapsed (s1_elapsed)
    );

    fsa_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .s1_valid   (s1_valid),
        .s1_meta    (s1_meta),
        .s1_elapsed (s1_elapsed),
        .slot_rate  (cfg_reg.slot_rate),
        .s3_valid   (s3_valid),
        .s3_meta    (s3_meta),
        .s3_slot    (s3_slot)
    );

    fsa_place u_place (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .s3_valid  (s3_valid),
        .s3_meta   (s3_meta),
        .s3_slot   (s3_slot),
        .max_push  (cfg_reg.max_push),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

`ifndef SYNTH
    // dropped or begin transactions never carry a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.verdict != VERDICT_APPEND) |-> out_data.slot_index == '0)
        else $error("slot index set on a transaction that was not appended");

    // a session begin reports empty totals
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.verdict == VERDICT_BEGIN) |->
            (out_data.submitted_total == '0) && (out_data.dropped_total == '0) &&
            (out_data.rendered_total == '0) && !out_data.stuck_flag)
        else $error("begin transaction with nonzero totals");

    // repeat drops only happen after the counter moved, which clears stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.verdict == VERDICT_REPEAT) |-> !out_data.stuck_flag)
        else $error("repeat drop while counter flagged stuck");
`endif

endmodule
